@@ hdl/dou_pkg.sv @@
// ----------------------------------------------------------------------------
// dou_pkg - shared types and constants of the odometry update block
// Field widths, register indexes, item kinds, sequencer states and the
// builder of the quarter-wave sine table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dou_pkg;

  // Field widths
  localparam int HEADING_W = 9;
  localparam int DELTA_W   = 16;
  localparam int DSUM_W    = DELTA_W + 1;
  localparam int IPD_W     = 20;
  localparam int POS_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // Parameter defaults
  localparam int POS_FRAC_BITS_DEF  = 16;
  localparam int TRIG_FRAC_BITS_DEF = 15;
  localparam int TRIG_FRAC_BITS_MAX = 17;

  // Two-entry queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INCHES_PER_DEGREE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X           = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y           = 2'd2;

  // Register reset values
  localparam logic [IPD_W-1:0]        IPD_RESET     = 20'd60394;
  localparam logic signed [POS_W-1:0] START_X_RESET = 32'sd2359296;
  localparam logic signed [POS_W-1:0] START_Y_RESET = 32'sd0;

  // Angle constants in degrees
  localparam int DEG_QUARTER = 90;
  localparam int DEG_HALF    = 180;
  localparam int DEG_FULL    = 360;
  localparam int DEG_ROTATE  = 450;

  // pi in Q.30
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef enum logic {
    OP_MOVE    = 1'b0,
    OP_RESTART = 1'b1
  } dou_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOVE,
    ST_X_LO,
    ST_X_HI,
    ST_Y_LO,
    ST_Y_HI,
    ST_Y_SUM,
    ST_Y_ADD,
    ST_DONE
  } dou_state_t;

  // Sine magnitudes for 0..90 degrees, widest supported fraction
  typedef logic [TRIG_FRAC_BITS_MAX-1:0] trig_rom_t [0:DEG_QUARTER];

  // Unsigned shift-subtract quotient, used only while building the table
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    int              i;
    quo = 0;
    rem = 0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sine in Q.30 from a ten-term Taylor series, products truncated
  function automatic longint sin_q30(input int unsigned d);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    int unsigned     k;
    x    = udiv64(64'(d) * PI_Q30, 64'(DEG_HALF));
    x2   = (x * x) >> 30;
    term = x;
    pos  = 0;
    neg  = 0;
    for (k = 0; k < 10; k++) begin
      if (k[0]) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
      term = udiv64((term * x2) >> 30, 64'((2 * k + 2) * (2 * k + 3)));
    end
    return longint'(pos) - longint'(neg);
  endfunction

  // Round each entry to tfb fraction bits and clamp it between zero and the Q1 maximum
  function automatic trig_rom_t build_trig_rom(input int unsigned tfb);
    trig_rom_t   rom;
    longint      v;
    longint      r;
    longint      lim;
    int unsigned d;
    lim = (longint'(1) << tfb) - 1;
    for (d = 0; d <= DEG_QUARTER; d++) begin
      v = sin_q30(d);
      r = (v + (longint'(1) << (29 - tfb))) >>> (30 - tfb);
      if (r > lim) begin
        r = lim;
      end
      if (r < 0) begin
        r = 0;
      end
      rom[d] = TRIG_FRAC_BITS_MAX'(r);
    end
    return rom;
  endfunction

endpackage

@@ hdl/dou_in_if.sv @@
// ----------------------------------------------------------------------------
// dou_in_if - input item channel
// Heading, encoder changes and restart flag with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dou_in_if;
  import dou_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [HEADING_W-1:0]        compass_heading;
  logic signed [DELTA_W-1:0]   left_delta;
  logic signed [DELTA_W-1:0]   right_delta;
  logic                        restart;

  modport source (
    output valid, compass_heading, left_delta, right_delta, restart,
    input  ready
  );

  modport sink (
    input  valid, compass_heading, left_delta, right_delta, restart,
    output ready
  );
endinterface

@@ hdl/dou_out_if.sv @@
// ----------------------------------------------------------------------------
// dou_out_if - result item channel
// Updated position and the math angle used, with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dou_out_if;
  import dou_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [POS_W-1:0]   x_position;
  logic signed [POS_W-1:0]   y_position;
  logic [HEADING_W-1:0]      heading_used;

  modport source (
    output valid, x_position, y_position, heading_used,
    input  ready
  );

  modport sink (
    input  valid, x_position, y_position, heading_used,
    output ready
  );
endinterface

@@ hdl/dou_cfg_if.sv @@
// ----------------------------------------------------------------------------
// dou_cfg_if - configuration write channel
// Register index and write data with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dou_cfg_if;
  import dou_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DAT_W-1:0]  data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

@@ hdl/differential_odometry_update.sv @@
// ----------------------------------------------------------------------------
// differential_odometry_update - dead-reckoning position integrator
// Each item carries a clockwise compass heading and left/right encoder
// changes; the block turns the heading into a math angle, scales the mean
// encoder change to inches and adds its cos/sin projections to saturating
// Q16.16 X/Y positions, giving one result item per input item. A restart
// item reloads the start position instead. In the back end a move item
// uses one shared multiplier five times (scale, then low and high partial
// products for cos and for sin) plus rounding, saturation and the output
// load; a restart item goes straight to the output load. A two-entry
// queue in front lets up to two more items be taken while one is worked
// on, and the result register lets the back end finish an item while the
// previous result still waits downstream. Configuration writes are taken
// every cycle and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module differential_odometry_update #(
  parameter int POS_FRAC_BITS  = dou_pkg::POS_FRAC_BITS_DEF,
  parameter int TRIG_FRAC_BITS = dou_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  dou_in_if.sink      in_chan,
  dou_out_if.source   out_chan,
  dou_cfg_if.sink     cfg_chan
);
  import dou_pkg::*;

  // Queue entry: kind, math angle, encoder sum, cos, sin
  localparam int ENT_W = 1 + HEADING_W + DSUM_W + 2 * (TRIG_FRAC_BITS + 1);

  logic             push_valid;
  logic             push_ready;
  logic [ENT_W-1:0] push_data;
  logic             pop_valid;
  logic             pop_ready;
  logic [ENT_W-1:0] pop_data;

  // Front: classify the item, wrap the angle and fetch trig values
  dou_front #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_front (
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Hold classified items while the sequencer is busy
  dou_queue #(
    .DATA_W (ENT_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: integrate, saturate and present the result
  dou_back #(
    .POS_FRAC_BITS  (POS_FRAC_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .cfg_chan  (cfg_chan),
    .out_chan  (out_chan)
  );

endmodule

@@ hdl/dou_front.sv @@
// ----------------------------------------------------------------------------
// dou_front - item classifier
// Map compass heading to math angle, look up cos/sin, sum encoder changes
// and pack one queue entry per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dou_front #(
  parameter int TRIG_FRAC_BITS = dou_pkg::TRIG_FRAC_BITS_DEF
) (
  dou_in_if.sink                                         in_chan,
  output logic                                           push_valid,
  input  logic                                           push_ready,
  output logic [dou_pkg::HEADING_W + dou_pkg::DSUM_W
                + 2 * (TRIG_FRAC_BITS + 1):0]            push_data
);
  import dou_pkg::*;

  localparam int TRIG_W = TRIG_FRAC_BITS + 1;
  localparam trig_rom_t TRIG_ROM = build_trig_rom(TRIG_FRAC_BITS);

  // Signed sine of an angle in 0..359 via quarter-wave symmetry
  function automatic logic signed [TRIG_W-1:0] trig_at(input logic [HEADING_W-1:0] a);
    logic                       neg;
    logic [HEADING_W-1:0]       m;
    logic [HEADING_W-1:0]       idx;
    logic signed [TRIG_W-1:0]   mag;
    neg = (a >= HEADING_W'(DEG_HALF));
    m   = neg ? (a - HEADING_W'(DEG_HALF)) : a;
    idx = (m <= HEADING_W'(DEG_QUARTER)) ? m : (HEADING_W'(DEG_HALF) - m);
    mag = $signed({1'b0, TRIG_ROM[idx[6:0]][TRIG_FRAC_BITS-1:0]});
    return neg ? -mag : mag;
  endfunction

  logic signed [HEADING_W+1:0]  rot;
  logic signed [HEADING_W+1:0]  rot_wrap;
  logic [HEADING_W-1:0]         ang;
  logic [HEADING_W:0]           cos_ang_ext;
  logic [HEADING_W-1:0]         cos_ang;
  logic signed [DSUM_W-1:0]     dsum;
  logic signed [TRIG_W-1:0]     cos_val;
  logic signed [TRIG_W-1:0]     sin_val;
  dou_op_t                      op;

  always_comb begin
    // Clockwise compass to counterclockwise math angle, wrapped to 0..359
    rot = (HEADING_W+2)'(DEG_ROTATE) - $signed({2'b00, in_chan.compass_heading});
    if (rot >= (HEADING_W+2)'(DEG_FULL)) begin
      rot_wrap = rot - (HEADING_W+2)'(DEG_FULL);
    end else if (rot < 0) begin
      rot_wrap = rot + (HEADING_W+2)'(DEG_FULL);
    end else begin
      rot_wrap = rot;
    end
    ang = rot_wrap[HEADING_W-1:0];

    // cos(a) = sin(a + 90)
    cos_ang_ext = {1'b0, ang} + (HEADING_W+1)'(DEG_QUARTER);
    if (cos_ang_ext >= (HEADING_W+1)'(DEG_FULL)) begin
      cos_ang_ext = cos_ang_ext - (HEADING_W+1)'(DEG_FULL);
    end
    cos_ang = cos_ang_ext[HEADING_W-1:0];

    cos_val = trig_at(cos_ang);
    sin_val = trig_at(ang);
    dsum    = {in_chan.left_delta[DELTA_W-1], in_chan.left_delta}
            + {in_chan.right_delta[DELTA_W-1], in_chan.right_delta};
    op      = in_chan.restart ? OP_RESTART : OP_MOVE;
  end

  assign push_valid    = in_chan.valid;
  assign in_chan.ready = push_ready;
  assign push_data     = {op, ang, dsum, cos_val, sin_val};

endmodule

@@ hdl/dou_queue.sv @@
// ----------------------------------------------------------------------------
// dou_queue - short FIFO between classifier and sequencer
// Lets the front take items while the back is busy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dou_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = dou_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [0:DEPTH-1];
  logic [PTR_W-1:0]  wptr_r;
  logic [PTR_W-1:0]  wptr_nxt;
  logic [PTR_W-1:0]  rptr_r;
  logic [PTR_W-1:0]  rptr_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

@@ hdl/dou_back.sv @@
// ----------------------------------------------------------------------------
// dou_back - integration sequencer
// Holds configuration and position, runs each move through one shared
// multiplier, rounds, saturates and presents the result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dou_back #(
  parameter int POS_FRAC_BITS  = dou_pkg::POS_FRAC_BITS_DEF,
  parameter int TRIG_FRAC_BITS = dou_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           pop_valid,
  output logic                                           pop_ready,
  input  logic [dou_pkg::HEADING_W + dou_pkg::DSUM_W
                + 2 * (TRIG_FRAC_BITS + 1):0]            pop_data,
  dou_cfg_if.sink                                        cfg_chan,
  dou_out_if.source                                      out_chan
);
  import dou_pkg::*;

  localparam int TRIG_W  = TRIG_FRAC_BITS + 1;
  localparam int MOVE_W  = DSUM_W + IPD_W + 1;           // sum times scale
  localparam int LO_W    = (MOVE_W + 1) / 2;
  localparam int HI_W    = MOVE_W - LO_W;
  localparam int MA_W    = LO_W + 1;
  localparam int MB_W    = (IPD_W + 1 > TRIG_W) ? IPD_W + 1 : TRIG_W;
  localparam int MUL_W   = MA_W + MB_W;
  localparam int P_W     = MOVE_W + TRIG_W;              // full move times trig
  localparam int SHIFT   = 21 + TRIG_FRAC_BITS - POS_FRAC_BITS;
  localparam int R_W     = P_W + 1 - SHIFT;
  localparam int SUM_W   = ((R_W > POS_W) ? R_W : POS_W) + 1;
  localparam logic [P_W:0] HALF = {{P_W{1'b0}}, 1'b1} << (SHIFT - 1);

  // Add a rounded move to a position and clamp to 32 bits
  function automatic logic signed [POS_W-1:0] sat_add(
    input logic signed [POS_W-1:0] acc,
    input logic [P_W:0]            p
  );
    logic [R_W-1:0]           rnd;
    logic signed [SUM_W-1:0]  s;
    rnd = p[P_W:SHIFT];
    s   = $signed({{(SUM_W-POS_W){acc[POS_W-1]}}, acc})
        + $signed({{(SUM_W-R_W){rnd[R_W-1]}}, rnd});
    if ((&s[SUM_W-1:POS_W-1]) || !(|s[SUM_W-1:POS_W-1])) begin
      return s[POS_W-1:0];
    end else if (s[SUM_W-1]) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

  // Merge the low and high partial products and add the rounding half
  function automatic logic [P_W:0] merge(
    input logic [MUL_W-1:0] lo,
    input logic [MUL_W-1:0] hi
  );
    logic [P_W:0] lo_ext;
    logic [P_W:0] hi_ext;
    lo_ext = {{(P_W+1-MUL_W){lo[MUL_W-1]}}, lo};
    hi_ext = {{(P_W+1-MUL_W){hi[MUL_W-1]}}, hi};
    return lo_ext + (hi_ext << LO_W) + HALF;
  endfunction

  // Queue entry fields
  dou_op_t                    ent_op;
  logic [HEADING_W-1:0]       ent_ang;
  logic [DSUM_W-1:0]          ent_sum;
  logic [TRIG_W-1:0]          ent_cos;
  logic [TRIG_W-1:0]          ent_sin;

  assign ent_sin = pop_data[TRIG_W-1:0];
  assign ent_cos = pop_data[2*TRIG_W-1:TRIG_W];
  assign ent_sum = pop_data[2*TRIG_W+DSUM_W-1:2*TRIG_W];
  assign ent_ang = pop_data[2*TRIG_W+DSUM_W+HEADING_W-1:2*TRIG_W+DSUM_W];
  assign ent_op  = dou_op_t'(pop_data[2*TRIG_W+DSUM_W+HEADING_W]);

  dou_state_t                 state_r, state_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [POS_W-1:0]    x_acc_r, x_acc_nxt;
  logic signed [POS_W-1:0]    y_acc_r, y_acc_nxt;
  logic [IPD_W-1:0]           ipd_r;
  logic signed [POS_W-1:0]    start_x_r;
  logic signed [POS_W-1:0]    start_y_r;

  logic [HEADING_W-1:0]       ang_r, ang_nxt;
  logic [DSUM_W-1:0]          sum_r, sum_nxt;
  logic [TRIG_W-1:0]          cos_r, cos_nxt;
  logic [TRIG_W-1:0]          sin_r, sin_nxt;
  logic [MOVE_W-1:0]          move_r, move_nxt;
  logic [MUL_W-1:0]           prod_r, prod_nxt;
  logic [MUL_W-1:0]           lo_r, lo_nxt;
  logic [P_W:0]               p_r, p_nxt;
  logic signed [POS_W-1:0]    out_x_r, out_x_nxt;
  logic signed [POS_W-1:0]    out_y_r, out_y_nxt;
  logic [HEADING_W-1:0]       out_head_r, out_head_nxt;

  logic signed [MA_W-1:0]     mul_a;
  logic signed [MB_W-1:0]     mul_b;
  logic signed [MUL_W-1:0]    mul_p;
  logic [TRIG_W-1:0]          trig_sel;

  // Shared multiplier: operands chosen by sequencer step
  always_comb begin
    trig_sel = ((state_r == ST_Y_LO) || (state_r == ST_Y_HI)) ? sin_r : cos_r;
    case (state_r)
      ST_MOVE: begin
        mul_a = $signed({{(MA_W-DSUM_W){sum_r[DSUM_W-1]}}, sum_r});
        mul_b = $signed({{(MB_W-IPD_W){1'b0}}, ipd_r});
      end
      ST_X_LO, ST_Y_LO: begin
        mul_a = $signed({{(MA_W-LO_W){1'b0}}, move_r[LO_W-1:0]});
        mul_b = $signed({{(MB_W-TRIG_W){trig_sel[TRIG_W-1]}}, trig_sel});
      end
      ST_X_HI, ST_Y_HI: begin
        mul_a = $signed({{(MA_W-HI_W){move_r[MOVE_W-1]}}, move_r[MOVE_W-1:LO_W]});
        mul_b = $signed({{(MB_W-TRIG_W){trig_sel[TRIG_W-1]}}, trig_sel});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    x_acc_nxt     = x_acc_r;
    y_acc_nxt     = y_acc_r;
    ang_nxt       = ang_r;
    sum_nxt       = sum_r;
    cos_nxt       = cos_r;
    sin_nxt       = sin_r;
    move_nxt      = move_r;
    prod_nxt      = prod_r;
    lo_nxt        = lo_r;
    p_nxt         = p_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_head_nxt  = out_head_r;
    pop_ready     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          ang_nxt = ent_ang;
          sum_nxt = ent_sum;
          cos_nxt = ent_cos;
          sin_nxt = ent_sin;
          if (ent_op == OP_RESTART) begin
            x_acc_nxt = start_x_r;
            y_acc_nxt = start_y_r;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_MOVE;
          end
        end
      end
      ST_MOVE: begin
        move_nxt  = mul_p[MOVE_W-1:0];
        state_nxt = ST_X_LO;
      end
      ST_X_LO: begin
        prod_nxt  = mul_p;
        state_nxt = ST_X_HI;
      end
      ST_X_HI: begin
        lo_nxt    = prod_r;
        prod_nxt  = mul_p;
        state_nxt = ST_Y_LO;
      end
      ST_Y_LO: begin
        p_nxt     = merge(lo_r, prod_r);
        prod_nxt  = mul_p;
        state_nxt = ST_Y_HI;
      end
      ST_Y_HI: begin
        x_acc_nxt = sat_add(x_acc_r, p_r);
        lo_nxt    = prod_r;
        prod_nxt  = mul_p;
        state_nxt = ST_Y_SUM;
      end
      ST_Y_SUM: begin
        p_nxt     = merge(lo_r, prod_r);
        state_nxt = ST_Y_ADD;
      end
      ST_Y_ADD: begin
        y_acc_nxt = sat_add(y_acc_r, p_r);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Load the output register once the previous result is gone
        if (!out_valid_r || out_chan.ready) begin
          out_x_nxt     = x_acc_r;
          out_y_nxt     = y_acc_r;
          out_head_nxt  = ang_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      x_acc_r     <= START_X_RESET;
      y_acc_r     <= START_Y_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      x_acc_r     <= x_acc_nxt;
      y_acc_r     <= y_acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ang_r      <= ang_nxt;
    sum_r      <= sum_nxt;
    cos_r      <= cos_nxt;
    sin_r      <= sin_nxt;
    move_r     <= move_nxt;
    prod_r     <= prod_nxt;
    lo_r       <= lo_nxt;
    p_r        <= p_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_head_r <= out_head_nxt;
  end

  // Configuration registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ipd_r     <= IPD_RESET;
      start_x_r <= START_X_RESET;
      start_y_r <= START_Y_RESET;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_INCHES_PER_DEGREE: ipd_r     <= cfg_chan.data[IPD_W-1:0];
        CFG_START_X:           start_x_r <= $signed(cfg_chan.data[POS_W-1:0]);
        CFG_START_Y:           start_y_r <= $signed(cfg_chan.data[POS_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  assign cfg_chan.ready        = 1'b1;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.x_position   = out_x_r;
  assign out_chan.y_position   = out_y_r;
  assign out_chan.heading_used = out_head_r;

endmodule

@@ tb/tb_differential_odometry_update.sv @@
// ----------------------------------------------------------------------------
// tb_differential_odometry_update - odometry update block testbench
// Drives heading/encoder items and register writes into the block and checks
// every result item against an in-bench fixed-point position tracker. A
// short directed part hits the heading wrap, delta extremes, restart and
// saturation; random phases follow under three sender/receiver idle mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_differential_odometry_update;
  import dou_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 11;
  // Extra wait once every owed result has been taken
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int MAX_REPORTS   = 60;
  localparam int RANDOM_ITEMS  = 270;
  localparam int TIMEOUT_NS    = 5_000_000;

  // Index past the last register; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Fraction bits dropped when the move product goes back to position format;
  // 21 = 20 bits of inches_per_degree plus the halving of the delta sum
  localparam int ROUND_SHIFT = 21 + TRIG_FRAC_BITS_DEF - POS_FRAC_BITS_DEF;

  localparam logic signed [POS_W-1:0]   POS_MAX   = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0]   POS_MIN   = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [IPD_W-1:0]          IPD_MAX   = '1;
  localparam logic signed [DELTA_W-1:0] DELTA_MAX = {1'b0, {(DELTA_W-1){1'b1}}};
  localparam logic signed [DELTA_W-1:0] DELTA_MIN = {1'b1, {(DELTA_W-1){1'b0}}};

  typedef struct packed {
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic [HEADING_W-1:0]    angle;
  } position_t;

  logic clk = 1'b0;
  logic rst_n;

  dou_in_if  in_chan();
  dou_out_if out_chan();
  dou_cfg_if cfg_chan();

  differential_odometry_update u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Tracker state: registers and accumulators as they stand after reset
  logic [IPD_W-1:0]        ipd_track     = IPD_RESET;
  logic signed [POS_W-1:0] start_x_track = START_X_RESET;
  logic signed [POS_W-1:0] start_y_track = START_Y_RESET;
  logic signed [POS_W-1:0] x_track       = START_X_RESET;
  logic signed [POS_W-1:0] y_track       = START_Y_RESET;

  // Sine magnitudes for 0..90 degrees at the block's trig precision
  longint sine_table [0:DEG_QUARTER];

  // Positions still owed by the block, oldest first
  position_t pending_positions[$];

  int fail_count      = 0;
  int items_sent      = 0;
  int restarts_sent   = 0;
  int results_checked = 0;
  int clamp_events    = 0;
  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Fixed-point position tracker
  // --------------------------------------------------------------------------

  // Sine in Q.30: alternating Taylor sum, each product truncated to Q.30
  function automatic longint taylor_sine_q30(int unsigned deg);
    longint unsigned rad;
    longint unsigned rad_sq;
    longint unsigned term;
    longint unsigned pos_sum;
    longint unsigned neg_sum;
    int              k;
    rad     = 64'(deg) * PI_Q30 / 64'd180;
    rad_sq  = (rad * rad) >> 30;
    term    = rad;
    pos_sum = 0;
    neg_sum = 0;
    for (k = 0; k < 10; k++) begin
      if (k % 2 == 0) begin
        pos_sum += term;
      end else begin
        neg_sum += term;
      end
      term = ((term * rad_sq) >> 30) / 64'((2 * k + 2) * (2 * k + 3));
    end
    return longint'(pos_sum) - longint'(neg_sum);
  endfunction

  // Round half up to the trig fraction width and clamp into the Q1 range
  function automatic longint sine_entry(int unsigned deg);
    longint lim;
    longint rounded;
    lim     = (longint'(1) <<< TRIG_FRAC_BITS_DEF) - 1;
    rounded = (taylor_sine_q30(deg) + (longint'(1) <<< (29 - TRIG_FRAC_BITS_DEF)))
              >>> (30 - TRIG_FRAC_BITS_DEF);
    if (rounded > lim) begin
      rounded = lim;
    end
    if (rounded < 0) begin
      rounded = 0;
    end
    return rounded;
  endfunction

  // Signed sine of any angle in 0..359 by quarter-wave folding
  function automatic longint sine_of(int unsigned ang);
    int unsigned folded;
    folded = ang % DEG_HALF;
    if (folded > DEG_QUARTER) begin
      folded = DEG_HALF - folded;
    end
    return ((ang % DEG_FULL) < DEG_HALF) ? sine_table[folded] : -sine_table[folded];
  endfunction

  // Project the travel onto one axis, round to nearest with ties upward
  function automatic longint project_travel(longint travel, longint trig);
    return (travel * trig + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
  endfunction

  function automatic logic signed [POS_W-1:0] clamp_pos(longint sum);
    if (sum > longint'(POS_MAX)) begin
      clamp_events++;
      return POS_MAX;
    end
    if (sum < longint'(POS_MIN)) begin
      clamp_events++;
      return POS_MIN;
    end
    return POS_W'(sum);
  endfunction

  // Advance the tracker by one item and return the position it must report
  function automatic position_t advance_position(logic [HEADING_W-1:0]        compass,
                                                 logic signed [DELTA_W-1:0]   left,
                                                 logic signed [DELTA_W-1:0]   right,
                                                 logic                        restart);
    position_t res;
    int        angle;
    longint    travel;
    // Clockwise compass to counterclockwise math angle, always in 0..359
    angle = (DEG_ROTATE - int'(compass)) % DEG_FULL;
    if (angle < 0) begin
      angle += DEG_FULL;
    end
    if (restart) begin
      x_track = start_x_track;
      y_track = start_y_track;
    end else begin
      travel  = (longint'(left) + longint'(right)) * longint'(ipd_track);
      x_track = clamp_pos(longint'(x_track)
                          + project_travel(travel, sine_of((angle + DEG_QUARTER) % DEG_FULL)));
      y_track = clamp_pos(longint'(y_track) + project_travel(travel, sine_of(angle)));
    end
    res.x_pos = x_track;
    res.y_pos = y_track;
    res.angle = HEADING_W'(angle);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what, longint got, longint want);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // Sample everything at the rising edge: register writes first, then taken
  // items, then results, so the tracker sees events in the block's order.
  always @(posedge clk) begin
    position_t want;
    if (rst_n) begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.index)
          CFG_INCHES_PER_DEGREE: ipd_track     = cfg_chan.data[IPD_W-1:0];
          CFG_START_X:           start_x_track = cfg_chan.data;
          CFG_START_Y:           start_y_track = cfg_chan.data;
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready) begin
        pending_positions.push_back(advance_position(in_chan.compass_heading,
                                                     in_chan.left_delta,
                                                     in_chan.right_delta,
                                                     in_chan.restart));
      end
      if (out_chan.valid && out_chan.ready) begin
        if (pending_positions.size() == 0) begin
          report_mismatch("result with nothing pending", longint'(out_chan.x_position), 0);
        end else begin
          want = pending_positions.pop_front();
          results_checked++;
          if (out_chan.x_position !== want.x_pos) begin
            report_mismatch("x_position", longint'(out_chan.x_position), longint'(want.x_pos));
          end
          if (out_chan.y_position !== want.y_pos) begin
            report_mismatch("y_position", longint'(out_chan.y_position), longint'(want.y_pos));
          end
          if (out_chan.heading_used !== want.angle) begin
            report_mismatch("heading_used", longint'(out_chan.heading_used),
                            longint'(want.angle));
          end
        end
      end
    end
  end

  // Receiver: drop ready at random in the current idle share
  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Drivers (enter and leave at a falling edge)
  // --------------------------------------------------------------------------

  task automatic send_item(logic [HEADING_W-1:0]      compass,
                           logic signed [DELTA_W-1:0] left,
                           logic signed [DELTA_W-1:0] right,
                           dou_op_t                   op);
    // Hold valid low for a random gap, then present the item until taken
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid           = 1'b1;
    in_chan.compass_heading = compass;
    in_chan.left_delta      = left;
    in_chan.right_delta     = right;
    in_chan.restart         = (op == OP_RESTART);
    @(posedge clk);
    while (!in_chan.ready) begin
      @(posedge clk);
    end
    items_sent++;
    if (op == OP_RESTART) begin
      restarts_sent++;
    end
    @(negedge clk);
  endtask

  // Stop sending, wait for every owed result, then let the back end settle
  task automatic wait_until_idle();
    int waited;
    in_chan.valid = 1'b0;
    waited        = 0;
    while (pending_positions.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] value);
    wait_until_idle();
    cfg_chan.valid = 1'b1;
    cfg_chan.index = index;
    cfg_chan.data  = value;
    @(posedge clk);
    while (!cfg_chan.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_chan.valid = 1'b0;
  endtask

  // Delta mix: extremes, small values around zero, and full-width noise
  function automatic logic signed [DELTA_W-1:0] random_delta();
    case ($urandom_range(9))
      0:       return DELTA_MAX;
      1:       return DELTA_MIN;
      2, 3, 4: return DELTA_W'(int'($urandom_range(400)) - 200);
      default: return DELTA_W'($urandom());
    endcase
  endfunction

  task automatic send_random_item();
    logic [HEADING_W-1:0] compass;
    dou_op_t              op;
    // Mostly legal headings; a fifth in the 360..511 wrap region
    if ($urandom_range(4) == 0) begin
      compass = HEADING_W'($urandom_range((1 << HEADING_W) - 1, DEG_FULL));
    end else begin
      compass = HEADING_W'($urandom_range(DEG_FULL - 1));
    end
    op = ($urandom_range(15) == 0) ? OP_RESTART : OP_MOVE;
    send_item(compass, random_delta(), random_delta(), op);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // A zero move straight after reset must report the reset start position
  task automatic test_reset_position();
    send_item(9'd90, '0, '0, OP_MOVE);
  endtask

  // Cardinal headings, the last legal one, and the out-of-range wrap region
  task automatic test_heading_wrap();
    send_item(9'd0,   16'sd100, 16'sd140, OP_MOVE);
    send_item(9'd90,  16'sd100, 16'sd140, OP_MOVE);
    send_item(9'd180, 16'sd100, 16'sd140, OP_MOVE);
    send_item(9'd270, 16'sd100, 16'sd140, OP_MOVE);
    send_item(9'd359, 16'sd100, 16'sd140, OP_MOVE);
    send_item(9'd360, 16'sd100, 16'sd140, OP_MOVE);
    send_item(9'd449, 16'sd100, 16'sd140, OP_MOVE);
    send_item(9'd450, 16'sd100, 16'sd140, OP_MOVE);
    send_item(9'd511, 16'sd100, 16'sd140, OP_MOVE);
  endtask

  task automatic test_delta_extremes();
    send_item(9'd45, DELTA_MIN, DELTA_MIN, OP_MOVE);
    send_item(9'd45, DELTA_MAX, DELTA_MAX, OP_MOVE);
    send_item(9'd45, DELTA_MIN, DELTA_MAX, OP_MOVE);
    send_item(9'd45, DELTA_MAX, DELTA_MIN, OP_MOVE);
  endtask

  // Restart ignores its deltas but still reports its own angle
  task automatic test_restart();
    send_item(9'd300, 16'sd5000, -16'sd7000, OP_RESTART);
    send_item(9'd300, 16'sd5000, -16'sd7000, OP_MOVE);
  endtask

  // Register extremes, the unused index, and saturation at both limits
  task automatic test_register_extremes();
    write_register(CFG_INCHES_PER_DEGREE, CFG_DAT_W'(IPD_MAX));
    write_register(CFG_START_X, POS_MAX);
    write_register(CFG_START_Y, POS_MIN);
    write_register(CFG_UNUSED, 32'h1234_5678);
    send_item(9'd90, '0, '0, OP_RESTART);
    // Push X past the top and Y past the bottom, then pull Y back off its limit
    send_item(9'd90, DELTA_MAX, DELTA_MAX, OP_MOVE);
    send_item(9'd0,  DELTA_MIN, DELTA_MIN, OP_MOVE);
    send_item(9'd0,  DELTA_MAX, DELTA_MAX, OP_MOVE);
    write_register(CFG_START_X, POS_MIN);
    write_register(CFG_START_Y, POS_MAX);
    write_register(CFG_INCHES_PER_DEGREE, '0);
    send_item(9'd180, '0, '0, OP_RESTART);
    // Zero scale: even the largest move must leave the position alone
    send_item(9'd45, DELTA_MAX, DELTA_MAX, OP_MOVE);
    write_register(CFG_INCHES_PER_DEGREE, CFG_DAT_W'(IPD_RESET));
    write_register(CFG_START_X, START_X_RESET);
    write_register(CFG_START_Y, START_Y_RESET);
  endtask

  // One random phase: fresh registers, then noise mixed with straight runs
  // that drive a position into saturation and back out
  task automatic test_random_phase(int send_pct, int recv_pct, logic [IPD_W-1:0] ipd);
    int                        sent;
    int                        run_len;
    int                        mag;
    bit                        forward;
    logic [HEADING_W-1:0]      compass;
    logic signed [DELTA_W-1:0] left;
    logic signed [DELTA_W-1:0] right;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_register(CFG_INCHES_PER_DEGREE, CFG_DAT_W'(ipd));
    write_register(CFG_START_X, $urandom());
    write_register(CFG_START_Y, $urandom());
    send_item(HEADING_W'($urandom_range(DEG_FULL - 1)), '0, '0, OP_RESTART);
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(7) == 0) begin
        compass = HEADING_W'($urandom_range(DEG_FULL - 1));
        forward = 1'($urandom_range(1));
        run_len = $urandom_range(12, 4);
        repeat (run_len) begin
          mag   = $urandom_range(32767, 8000);
          left  = DELTA_W'(forward ? mag : -mag);
          mag   = $urandom_range(32767, 8000);
          right = DELTA_W'(forward ? mag : -mag);
          send_item(compass, left, right, OP_MOVE);
          sent++;
        end
      end else begin
        send_random_item();
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    int d;
    position_t leftover;
    rst_n                   = 1'b0;
    in_chan.valid           = 1'b0;
    in_chan.compass_heading = '0;
    in_chan.left_delta      = '0;
    in_chan.right_delta     = '0;
    in_chan.restart         = 1'b0;
    cfg_chan.valid          = 1'b0;
    cfg_chan.index          = CFG_INCHES_PER_DEGREE;
    cfg_chan.data           = '0;
    for (d = 0; d <= DEG_QUARTER; d++) begin
      sine_table[d] = sine_entry(d);
    end

    // Directed part runs under the first idle mix
    send_idle_pct = 25;
    recv_idle_pct = 85;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_position();
    test_heading_wrap();
    test_delta_extremes();
    test_restart();
    test_register_extremes();

    test_random_phase(25, 85, IPD_RESET);
    test_random_phase(85, 25, IPD_MAX);
    test_random_phase(0, 0, IPD_W'($urandom_range(200000, 1000)));

    wait_until_idle();
    while (pending_positions.size() != 0) begin
      leftover = pending_positions.pop_front();
      report_mismatch("missing result, x_position", 0, longint'(leftover.x_pos));
    end

    $display("sent %0d items (%0d restarts), checked %0d results, %0d saturating updates",
             items_sent, restarts_sent, results_checked, clamp_events);
    $display("idle mixes sender/receiver 25/85, 85/25 and none; %0d mismatches", fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure
  initial begin
    #(TIMEOUT_NS);
    $display("timeout after %0d ns", TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/dou_pkg.sv
hdl/dou_in_if.sv
hdl/dou_out_if.sv
hdl/dou_cfg_if.sv
hdl/dou_front.sv
hdl/dou_queue.sv
hdl/dou_back.sv
hdl/differential_odometry_update.sv
tb/tb_differential_odometry_update.sv
